// File: rtl/olis_pkg.sv
// Shared types and codes for the ordered list block.
package olis_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_MODIFY = 2'd2,
    OP_SEARCH = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int FOUND_W = 4;
  localparam int COUNT_W = 5;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic               write;       // overwrite the cell at pos with value
    logic               shift_up;    // cells above pos take their lower neighbour
    logic               shift_down;  // cells at or above pos take their upper neighbour
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: rtl/olis_cell.sv
// One list entry: a value register with its neighbour shift and its search compare.
module olis_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  olis_pkg::cell_ctl_t        ctl,
  input  logic [olis_pkg::VALUE_W-1:0] prev_data,
  input  logic [olis_pkg::VALUE_W-1:0] next_data,
  output logic [olis_pkg::VALUE_W-1:0] data,
  output logic                       match
);
  import olis_pkg::*;

  localparam logic [31:0] IdxU = 32'(IDX);

  logic [VALUE_W-1:0] data_r;
  logic [VALUE_W-1:0] data_nxt;
  logic [31:0]        pos_ext;

  always_comb begin
    pos_ext  = 32'(ctl.pos);
    data_nxt = data_r;
    if (ctl.write && (pos_ext == IdxU)) begin
      data_nxt = ctl.value;
    end else if (ctl.shift_up && (pos_ext < IdxU)) begin
      data_nxt = prev_data;
    end else if (ctl.shift_down && (pos_ext <= IdxU)) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == ctl.value);

endmodule

// File: rtl/ordered_list_insert_delete_search.sv
// Top level of the ordered list: a row of entry cells with insert, delete, modify and search.
// Each accepted transaction passes through the pending step and then into the output register.
// Throughput: one transaction per cycle while out_tready holds no result back; the row of cells
// updates in the accepting cycle and the encoder finishes the search in the pending step.
// Reset: rst_n is synchronous and active low; it empties the list and the pipeline. The entry
// cells themselves are not reset, since no entry at or above the count is ever read.
module ordered_list_insert_delete_search #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [4:0] position, [36:5] value, [39:37] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  // Result transactions.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] found_position, [8:4] count, [15:9] zero
  output logic [1:0]  out_tuser   // [1:0] status
);
  import olis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // internal count width
  localparam int FW = $clog2(CAPACITY);       // cell index width
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  // Decoded input fields.
  func_t              op;
  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] val;
  logic               accept;

  assign op     = func_t'(in_tuser[1:0]);
  assign pos    = in_tdata[4:0];
  assign val    = in_tdata[36:5];
  assign accept = in_tvalid && in_tready;

  // List length and the second pipeline step, which holds one operation's outcome while the
  // search encoder works on the registered match vector.
  logic [CW-1:0]       count_r, count_nxt;
  logic                pend_r;
  logic                pend_search_r;
  status_t             pend_status_r;
  logic [CW-1:0]       pend_count_r;
  logic [CAPACITY-1:0] match_r;

  // Output register.
  logic                out_valid_r;
  status_t             out_status_r;
  logic [FOUND_W-1:0]  out_found_r;
  logic [COUNT_W-1:0]  out_count_r;

  status_t             status_now;
  cell_ctl_t           ctl;
  logic                advance;

  // The pending step moves on whenever the output register is empty or being emptied, and a
  // new transaction can enter whenever the pending step is free or moving on.
  assign advance   = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || advance;

  // Bound checks and the command to the cells. Only an accepted operation that passes its
  // checks touches the cells or the count; a rejected one leaves the list as it was.
  always_comb begin
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    pos_x          = XW'(pos);
    cnt_x          = XW'(count_r);
    status_now     = ST_OK;
    count_nxt      = count_r;
    ctl.write      = 1'b0;
    ctl.shift_up   = 1'b0;
    ctl.shift_down = 1'b0;
    ctl.pos        = pos;
    ctl.value      = val;
    case (op)
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_now = ST_BADPOS;
        end else if (count_r == CapC) begin
          status_now = ST_FULL;
        end else begin
          ctl.write    = accept;
          ctl.shift_up = accept;
          count_nxt    = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (pos_x >= cnt_x) begin
          status_now = ST_BADPOS;
        end else begin
          ctl.shift_down = accept;
          count_nxt      = count_r - CW'(1);
        end
      end
      OP_MODIFY: begin
        if (pos_x >= cnt_x) begin
          status_now = ST_BADPOS;
        end else begin
          ctl.write = accept;
        end
      end
      OP_SEARCH: begin
        status_now = ST_OK;
      end
      default: begin
        status_now = ST_OK;
      end
    endcase
  end

  // The row of cells. Each cell sees its two neighbours; the ends see themselves, which is
  // harmless because the end values are never shifted into a live entry.
  logic [VALUE_W-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] match_nxt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] prev_d;
    logic [VALUE_W-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = cell_data[i];
    end else begin : g_prev
      assign prev_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_next
      assign next_d = cell_data[i+1];
    end

    olis_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );

    // Only entries below the current length take part in a search.
    assign match_nxt[i] = cell_match[i] && (32'(count_r) > 32'(i));
  end

  // Lowest matching position from the registered match vector.
  logic [FW-1:0] hit_idx;
  logic          hit_any;
  logic [31:0]   hit_ext;
  logic [31:0]   cnt_ext;

  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = FW'(i);
      end
    end
  end

  assign hit_any = |match_r;
  assign hit_ext = 32'(hit_idx);
  assign cnt_ext = 32'(pend_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        pend_r <= 1'b1;
      end else if (advance) begin
        pend_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_search_r <= (op == OP_SEARCH);
      pend_status_r <= status_now;
      pend_count_r  <= count_nxt;
      match_r       <= match_nxt;
    end
    if (advance) begin
      out_count_r <= cnt_ext[COUNT_W-1:0];
      if (pend_search_r) begin
        out_status_r <= hit_any ? ST_OK : ST_NOTFOUND;
        out_found_r  <= hit_any ? hit_ext[FOUND_W-1:0] : '0;
      end else begin
        out_status_r <= pend_status_r;
        out_found_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_found_r};
  assign out_tuser  = out_status_r;

endmodule

// File: rtl/olis_checker.sv
// Port-level checks for the ordered list, attached to the top level by a bind.
module olis_checker #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import olis_pkg::*;

  localparam logic [COUNT_W-1:0] CapM = COUNT_W'(CAPACITY);

  // The output register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown straight after reset");

  // A full-table answer always reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_FULL)) |-> (out_tdata[8:4] == CapM))
    else $error("table full reported with a list that is not full");

  // A nonzero found position comes only with a successful operation.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:0] != 4'd0)) |-> (out_tuser == ST_OK))
    else $error("found position given on a failed operation");

  // The length never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (CAPACITY < 32)) |-> (out_tdata[8:4] <= CapM))
    else $error("count above capacity");

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind ordered_list_insert_delete_search olis_checker #(.CAPACITY(CAPACITY)) u_olis_checker (.*);
